// File: hw/rtl/efhp_pkg.sv
// efhp_pkg: shared types and constants for the frame header parser.
// Used by every module of the block; no dependencies.
`default_nettype none

package efhp_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] LONG_HDR_MIN_VER = 8'd8;
  localparam logic [7:0] EXT_MARK         = 8'hff;
  localparam logic [2:0] POS_SAT          = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_BIG_ID  = 3'd3;
  localparam logic [2:0] ST_DROPPED = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [1:0] CFG_PROTO_VER = 2'd0;
  localparam logic [1:0] CFG_PARSE_EN  = 2'd1;
  localparam logic [1:0] CFG_NO_ACK_ID = 2'd2;

  localparam logic [7:0] RST_PROTO_VER = 8'd0;
  localparam logic       RST_PARSE_EN  = 1'b1;
  localparam logic [7:0] RST_NO_ACK_ID = 8'd143;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_id;
    logic [2:0] frame_status;
    logic       ack_request;
  } out_item_t;

  typedef struct packed {
    logic       has_pay;
    logic       has_stat;
    logic [7:0] pay_byte;
    logic [7:0] frame_id;
    logic [2:0] status;
    logic       ack;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/efhp_front.sv
// efhp_front: accepts frame bytes, tracks the header position and classifies
// each byte, queueing payload and frame-end bytes. Holds cfg regs. Uses efhp_pkg.
`default_nettype none

module efhp_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_idx,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire efhp_pkg::in_item_t  in_data,
  input  wire efhp_pkg::q_status_t q_stat,
  output logic                     q_push,
  output efhp_pkg::q_entry_t       q_wdata
);

  logic [7:0] proto_ver_r;
  logic       parse_en_r;
  logic [7:0] no_ack_id_r;

  logic [2:0] pos_r, pos_nxt;
  logic       ext_r, ext_nxt;
  logic [7:0] id_r, id_nxt;
  logic [2:0] err_r, err_nxt;

  logic       accept;
  logic       long_hdr;
  logic       hdr5;
  logic       pay;
  logic       short_frm;
  logic [2:0] st;
  logic [7:0] b;

  assign b        = in_data.data_byte;
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign long_hdr = proto_ver_r >= efhp_pkg::LONG_HDR_MIN_VER;

  always_comb begin
    ext_nxt = ext_r;
    id_nxt  = id_r;
    err_nxt = err_r;
    if (!parse_en_r) begin
      err_nxt = efhp_pkg::ST_DROPPED;
    end else if (long_hdr) begin
      if (pos_r == 3'd3) begin
        id_nxt = b;
      end
      if (pos_r == 3'd4 && b != 8'd0 && err_r == efhp_pkg::ST_OK) begin
        err_nxt = efhp_pkg::ST_BIG_ID;
      end
    end else begin
      if (pos_r == 3'd2) begin
        if (b == efhp_pkg::EXT_MARK) begin
          ext_nxt = 1'b1;
        end else begin
          id_nxt = b;
        end
      end
      if (pos_r == 3'd4 && ext_nxt) begin
        id_nxt = b;
      end
    end

    hdr5      = long_hdr || ext_nxt;
    pay       = (err_nxt == efhp_pkg::ST_OK) && (pos_r >= (hdr5 ? 3'd5 : 3'd3));
    short_frm = pos_r < (hdr5 ? 3'd4 : 3'd3);

    if (err_nxt == efhp_pkg::ST_DROPPED) begin
      st = efhp_pkg::ST_DROPPED;
    end else if (short_frm) begin
      st = efhp_pkg::ST_SHORT;
    end else begin
      st = err_nxt;
    end

    pos_nxt = (pos_r < efhp_pkg::POS_SAT) ? pos_r + 3'd1 : pos_r;
  end

  always_comb begin
    q_wdata          = '0;
    q_wdata.has_pay  = pay;
    q_wdata.has_stat = in_data.end_of_frame;
    q_wdata.pay_byte = b;
    q_wdata.status   = st;
    q_wdata.frame_id = (st == efhp_pkg::ST_OK) ? id_nxt : 8'd0;
    q_wdata.ack      = (st == efhp_pkg::ST_OK) && (id_nxt != no_ack_id_r);
  end

  assign q_push = accept && (pay || in_data.end_of_frame);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_ver_r <= efhp_pkg::RST_PROTO_VER;
      parse_en_r  <= efhp_pkg::RST_PARSE_EN;
      no_ack_id_r <= efhp_pkg::RST_NO_ACK_ID;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        efhp_pkg::CFG_PROTO_VER: proto_ver_r <= cfg_wdata;
        efhp_pkg::CFG_PARSE_EN:  parse_en_r  <= cfg_wdata[0];
        efhp_pkg::CFG_NO_ACK_ID: no_ack_id_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ext_r <= 1'b0;
      id_r  <= '0;
      err_r <= efhp_pkg::ST_OK;
    end else if (accept) begin
      if (in_data.end_of_frame) begin
        pos_r <= '0;
        ext_r <= 1'b0;
        id_r  <= '0;
        err_r <= efhp_pkg::ST_OK;
      end else begin
        pos_r <= pos_nxt;
        ext_r <= ext_nxt;
        id_r  <= id_nxt;
        err_r <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/efhp_queue.sv
// efhp_queue: short FIFO of classified entries between front and back.
// Uses efhp_pkg for the entry type and depth.
`default_nettype none

module efhp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire efhp_pkg::q_entry_t wdata,
  input  wire logic               pop,
  output efhp_pkg::q_entry_t      rdata,
  output efhp_pkg::q_status_t     stat
);

  efhp_pkg::q_entry_t mem_r [efhp_pkg::QDEPTH];

  logic [efhp_pkg::QPTR_W-1:0] wptr_r;
  logic [efhp_pkg::QPTR_W-1:0] rptr_r;
  logic [efhp_pkg::QCNT_W-1:0] cnt_r;
  logic                        do_push;
  logic                        do_pop;

  assign stat.full  = cnt_r == efhp_pkg::QCNT_W'(efhp_pkg::QDEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + efhp_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + efhp_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + efhp_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - efhp_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/efhp_back.sv
// efhp_back: drains queue entries onto the result channel, splitting an entry
// that carries both a payload byte and a status into two transactions. Uses efhp_pkg.
`default_nettype none

module efhp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire efhp_pkg::q_entry_t  q_rdata,
  input  wire efhp_pkg::q_status_t q_stat,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output efhp_pkg::out_item_t      out_data
);

  logic phase_r;
  logic out_acc;
  logic both;
  logic send_pay;

  assign out_valid = !q_stat.empty;
  assign out_acc   = out_valid && !out_stall;
  assign both      = q_rdata.has_pay && q_rdata.has_stat;
  assign send_pay  = q_rdata.has_pay && !phase_r;
  assign q_pop     = out_acc && (!both || phase_r);

  always_comb begin
    out_data = '0;
    if (send_pay) begin
      out_data.item_kind    = efhp_pkg::KIND_PAYLOAD;
      out_data.payload_byte = q_rdata.pay_byte;
    end else begin
      out_data.item_kind    = efhp_pkg::KIND_STATUS;
      out_data.frame_id     = q_rdata.frame_id;
      out_data.frame_status = q_rdata.status;
      out_data.ack_request  = q_rdata.ack;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (out_acc) begin
      phase_r <= both && !phase_r;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ezsp_frame_header_parser_core.sv
// ezsp_frame_header_parser_core: top level of the frame header parser.
// Instantiates efhp_front, efhp_queue and efhp_back; uses efhp_pkg.
//
// The block takes one frame byte per cycle while in_stall is low and strips
// the header (5 bytes when protocol_version is 8 or higher, otherwise the
// 3-byte legacy header, extended to 5 bytes by an 0xff at byte 2). Bytes
// past the header come out as payload transactions while the frame status
// is OK; the last byte of a frame also yields a status transaction with the
// frame id, status code and ack request. A result is registered in the
// 4-entry queue that separates the byte classifier from the result port,
// so input runs at one byte per cycle while the queue is not full; the
// result port delivers one transaction per cycle while out_stall is low,
// and a final byte with payload gives two transactions. Configuration
// writes through cfg_we/cfg_idx/cfg_wdata take effect on the next byte.
`default_nettype none

module ezsp_frame_header_parser_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_idx,
  input  wire logic [7:0]           cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire efhp_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output efhp_pkg::out_item_t       out_data
);

  efhp_pkg::q_entry_t  q_wdata;
  efhp_pkg::q_entry_t  q_rdata;
  efhp_pkg::q_status_t q_stat;
  logic                q_push;
  logic                q_pop;

  efhp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  efhp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  efhp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: hw/rtl/efhp_checker.sv
// efhp_checker: port-level assertions for the frame header parser.
// Uses efhp_pkg; bound to ezsp_frame_header_parser_core.
`default_nettype none

module efhp_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire efhp_pkg::out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_pay_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == efhp_pkg::KIND_PAYLOAD |->
      out_data.frame_id == 8'd0 && out_data.frame_status == efhp_pkg::ST_OK &&
      !out_data.ack_request)
    else $error("payload transaction carries status fields");

  a_stat_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == efhp_pkg::KIND_STATUS &&
      out_data.frame_status != efhp_pkg::ST_OK |->
      !out_data.ack_request && out_data.frame_id == 8'd0)
    else $error("failed frame reports id or ack");

  a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == efhp_pkg::KIND_STATUS |->
      out_data.payload_byte == 8'd0 &&
      (out_data.frame_status == efhp_pkg::ST_OK ||
       out_data.frame_status == efhp_pkg::ST_SHORT ||
       out_data.frame_status == efhp_pkg::ST_BIG_ID ||
       out_data.frame_status == efhp_pkg::ST_DROPPED))
    else $error("bad status transaction");

endmodule

bind ezsp_frame_header_parser_core efhp_checker u_efhp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for ezsp_frame_header_parser_core (frame header stripping).
// Depends on efhp_pkg and the core RTL; predicts payload and status transactions per byte.

module testbench;

  localparam int WDOG_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_idx = efhp_pkg::CFG_PROTO_VER;
  logic [7:0]          cfg_wdata = 8'd0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  efhp_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  efhp_pkg::out_item_t out_data;

  logic [7:0] reg_proto_ver;
  logic       reg_parse_en;
  logic [7:0] reg_no_ack_id;

  logic [2:0] frm_pos;
  logic       frm_ext;
  logic [7:0] frm_id;
  logic [2:0] frm_err;

  efhp_pkg::out_item_t expected_items[$];
  efhp_pkg::out_item_t want;

  int  errors = 0;
  int  n_bytes = 0;
  int  n_payloads = 0;
  int  n_statuses = 0;
  int  hold_left = 0;
  int  idle_cycles;
  bit  in_quiet = 1'b0;
  bit  out_quiet = 1'b0;

  ezsp_frame_header_parser_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int rand_idle();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int in_gap();
    if (in_quiet) return 0;
    if ($urandom_range(0, 99) < 55) return 0;
    return rand_idle();
  endfunction

  task automatic add_expected(input efhp_pkg::out_item_t item);
    expected_items = {expected_items, item};
  endtask

  task automatic predict_frame_byte(input logic [7:0] b, input logic eof);
    logic                long_hdr;
    logic [2:0]          pos;
    logic [2:0]          hdr_len;
    logic [2:0]          min_last;
    logic [2:0]          st;
    efhp_pkg::out_item_t item;
    long_hdr = (reg_proto_ver >= efhp_pkg::LONG_HDR_MIN_VER);
    pos = frm_pos;
    if (!reg_parse_en) begin
      frm_err = efhp_pkg::ST_DROPPED;
    end else if (long_hdr) begin
      if (pos == 3'd3) frm_id = b;
      if (pos == 3'd4 && b != 8'd0 && frm_err == efhp_pkg::ST_OK) frm_err = efhp_pkg::ST_BIG_ID;
    end else begin
      if (pos == 3'd2) begin
        if (b == efhp_pkg::EXT_MARK) frm_ext = 1'b1;
        else frm_id = b;
      end
      if (pos == 3'd4 && frm_ext) frm_id = b;
    end
    if (long_hdr || frm_ext) begin
      hdr_len = 3'd5;
      min_last = 3'd4;
    end else begin
      hdr_len = 3'd3;
      min_last = 3'd3;
    end
    if (frm_err == efhp_pkg::ST_OK && pos >= hdr_len) begin
      item = '0;
      item.item_kind = efhp_pkg::KIND_PAYLOAD;
      item.payload_byte = b;
      add_expected(item);
    end
    if (eof) begin
      if (frm_err == efhp_pkg::ST_DROPPED) st = efhp_pkg::ST_DROPPED;
      else if (pos < min_last) st = efhp_pkg::ST_SHORT;
      else st = frm_err;
      item = '0;
      item.item_kind = efhp_pkg::KIND_STATUS;
      item.frame_id = (st == efhp_pkg::ST_OK) ? frm_id : 8'd0;
      item.frame_status = st;
      item.ack_request = (st == efhp_pkg::ST_OK) && (frm_id != reg_no_ack_id);
      add_expected(item);
      frm_pos = 3'd0;
      frm_ext = 1'b0;
      frm_id = 8'd0;
      frm_err = efhp_pkg::ST_OK;
    end else if (pos < efhp_pkg::POS_SAT) begin
      frm_pos = pos + 3'd1;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int g;
    g = in_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, end_of_frame: eof};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame_byte(b, eof);
    n_bytes++;
  endtask

  // bytes go out first byte in the most significant position
  task automatic send_seq(input logic [63:0] bytes, input int len, input bit close);
    for (int i = 0; i < len; i++) begin
      send_byte(bytes[8 * (len - 1 - i) +: 8], close && i == len - 1);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] ver, input logic en, input logic [7:0] noack);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= efhp_pkg::CFG_PROTO_VER;
    cfg_wdata <= ver;
    @(negedge clk);
    cfg_idx <= efhp_pkg::CFG_PARSE_EN;
    cfg_wdata <= {7'd0, en};
    @(negedge clk);
    cfg_idx <= efhp_pkg::CFG_NO_ACK_ID;
    cfg_wdata <= noack;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_proto_ver = ver;
    reg_parse_en = en;
    reg_no_ack_id = noack;
  endtask

  task automatic send_random_frame();
    int         len;
    logic [7:0] id;
    logic [7:0] b;
    bit         ext;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 8);
    id = ($urandom_range(0, 5) == 0) ? reg_no_ack_id : 8'($urandom);
    ext = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (reg_proto_ver >= efhp_pkg::LONG_HDR_MIN_VER) begin
        if (i == 3) b = id;
        if (i == 4) b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
      end else begin
        if (i == 2) b = ext ? efhp_pkg::EXT_MARK : id;
        if (i == 4 && ext) b = id;
      end
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic run_random_phase(input int n_items, input logic [7:0] ver, input logic en,
                                  input logic [7:0] noack, input bit quiet);
    int start;
    configure(ver, en, noack);
    in_quiet = quiet;
    out_quiet = quiet;
    start = n_bytes;
    while (n_bytes - start < n_items) begin
      if ($urandom_range(0, 99) < 85) send_random_frame();
      else send_byte(8'($urandom), $urandom_range(0, 9) == 0);
    end
    in_quiet = 1'b0;
    out_quiet = 1'b0;
  endtask

  task automatic test_legacy_header();
    configure(efhp_pkg::RST_PROTO_VER, efhp_pkg::RST_PARSE_EN, efhp_pkg::RST_NO_ACK_ID);
    send_seq(64'h00ff8fff, 4, 1'b1);
    send_seq(64'h1122ff334455, 6, 1'b1);
    send_seq(64'h0102ff03, 4, 1'b1);
  endtask

  task automatic test_long_header();
    configure(8'd8, 1'b1, efhp_pkg::RST_NO_ACK_ID);
    send_seq(64'h0000007e00ff, 6, 1'b1);
    send_seq(64'hffffffff80, 5, 1'b1);
  endtask

  task automatic test_dropped_frames();
    configure(8'd0, 1'b0, efhp_pkg::RST_NO_ACK_ID);
    send_seq(64'h1020, 2, 1'b1);
  endtask

  task automatic test_version_switch();
    configure(8'd0, 1'b1, 8'd0);
    send_seq(64'h0102, 2, 1'b0);
    configure(8'd255, 1'b1, 8'd0);
    send_seq(64'h030000c3, 4, 1'b1);
  endtask

  task automatic test_backpressure();
    configure(8'd0, 1'b1, efhp_pkg::RST_NO_ACK_ID);
    in_quiet = 1'b1;
    hold_left = 80;
    for (int i = 0; i < 24; i++) send_byte((i == 2) ? 8'h42 : 8'($urandom), i == 23);
    in_quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(150, 8'd0, 1'b1, 8'd143, 1'b0);
    run_random_phase(160, 8'd7, 1'b1, 8'd0, 1'b0);
    run_random_phase(200, 8'd8, 1'b1, 8'd255, 1'b0);
    run_random_phase(160, 8'd255, 1'b1, 8'($urandom), 1'b0);
    run_random_phase(60, 8'($urandom), 1'b0, 8'($urandom), 1'b0);
    run_random_phase(170, 8'($urandom_range(1, 255)), 1'b1, 8'($urandom), 1'b1);
    run_random_phase(200, 8'd0, 1'b1, 8'($urandom), 1'b0);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (out_data.item_kind == efhp_pkg::KIND_STATUS) n_statuses++;
      else n_payloads++;
      if (expected_items.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = expected_items.pop_front();
        check_field("item_kind", 8'(want.item_kind), 8'(out_data.item_kind));
        check_field("payload_byte", want.payload_byte, out_data.payload_byte);
        check_field("frame_id", want.frame_id, out_data.frame_id);
        check_field("frame_status", 8'(want.frame_status), 8'(out_data.frame_status));
        check_field("ack_request", 8'(want.ack_request), 8'(out_data.ack_request));
      end
    end
  end

  initial begin
    int   run;
    logic lvl;
    run = 0;
    lvl = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        lvl = 1'b1;
        run = 0;
      end else if (out_quiet) begin
        lvl = 1'b0;
      end else if (run > 0) begin
        run--;
      end else begin
        lvl = ($urandom_range(0, 99) < 35);
        run = rand_idle();
      end
      out_stall <= lvl;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    reg_proto_ver = efhp_pkg::RST_PROTO_VER;
    reg_parse_en = efhp_pkg::RST_PARSE_EN;
    reg_no_ack_id = efhp_pkg::RST_NO_ACK_ID;
    frm_pos = 3'd0;
    frm_ext = 1'b0;
    frm_id = 8'd0;
    frm_err = efhp_pkg::ST_OK;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_legacy_header();
    test_long_header();
    test_dropped_frames();
    test_version_switch();
    test_backpressure();
    test_random_traffic();
    drain_results();

    $display("Sent %0d bytes over legacy, extended and long headers, dropped and stalled runs.",
             n_bytes);
    $display("Checked %0d payload and %0d status transactions.", n_payloads, n_statuses);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: ezsp_frame_header_parser_core.f
hw/rtl/efhp_pkg.sv
hw/rtl/efhp_front.sv
hw/rtl/efhp_queue.sv
hw/rtl/efhp_back.sv
hw/rtl/ezsp_frame_header_parser_core.sv
hw/rtl/efhp_checker.sv
bench/testbench.sv
